[rtl/tcw_pkg.sv]
// Package for the text console character writer.
// Holds field widths, default geometry, function codes, the command struct
// and the back-end state type. Depends on nothing.
package tcw_pkg;

  // Widths of the channel fields.
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // Default screen geometry.
  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  // Entries of the command queue between front and back.
  localparam int FIFO_DEPTH = 2;

  // Character code that moves the cursor to the next row.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  // Function codes on the input channel.
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

  // Operation class assigned by the front end.
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_SET,
    OP_READ
  } op_e;

  // Classified command handed from front to back.
  typedef struct packed {
    op_e               op;
    logic              in_range;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attribute;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    BK_INIT,
    BK_IDLE,
    BK_READ,
    BK_WRAP,
    BK_SCR_RD,
    BK_SCR_WR,
    BK_ZERO,
    BK_CLEAR,
    BK_PUT,
    BK_DONE
  } bk_state_e;

endpackage

[rtl/tcw_in_if.sv]
// Input channel of the text console character writer.
// Carries valid, ready and one request. Depends on tcw_pkg.
interface tcw_in_if import tcw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAR_W-1:0] char_code;
  logic [ATTR_W-1:0] attribute;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;

  modport source (output valid, func, char_code, attribute, col, row, input ready);
  modport sink   (input valid, func, char_code, attribute, col, row, output ready);
endinterface

[rtl/tcw_out_if.sv]
// Output channel of the text console character writer.
// Carries valid, ready and one result. Depends on tcw_pkg.
interface tcw_out_if import tcw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;

  modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_col, cursor_row, cell_char, cell_attr, output ready);
endinterface

[rtl/tcw_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcw_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tcw_front.sv]
// Front end: accepts requests and classifies them into queue commands.
// Depends on tcw_pkg and tcw_in_if.
module tcw_front import tcw_pkg::*; #(
  parameter int Cols = COLS_DEF,
  parameter int Rows = ROWS_DEF
) (
  tcw_in_if.sink     in_i,
  input  logic       init_done_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  // Take a request only once the store is cleared and the queue has room.
  assign in_i.ready = init_done_i && !full_i;
  assign push_o     = in_i.valid && in_i.ready;

  // Decode the function and spot newlines and reads outside the screen.
  always_comb begin
    cmd_o.char_code = in_i.char_code;
    cmd_o.attribute = in_i.attribute;
    cmd_o.col       = in_i.col;
    cmd_o.row       = in_i.row;
    cmd_o.in_range  = (32'(in_i.col) < Cols) && (32'(in_i.row) < Rows);
    case (in_i.func)
      FUNC_PUT:   cmd_o.op = (in_i.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
      FUNC_CLEAR: cmd_o.op = OP_CLEAR;
      FUNC_SET:   cmd_o.op = OP_SET;
      FUNC_READ:  cmd_o.op = OP_READ;
      default:    cmd_o.op = OP_READ;
    endcase
  end

endmodule

[rtl/tcw_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on tcw_pkg.
module tcw_fifo import tcw_pkg::*; #(
  parameter int Depth = FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o,
  output logic full_o
);

  localparam int PW = $clog2(Depth);
  localparam int NW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == NW'(Depth));
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/tcw_back.sv]
// Back end: sequencer that carries out commands on the screen store and
// the cursor, and holds the result register. Depends on tcw_pkg,
// tcw_out_if and tcw_ram.
module tcw_back import tcw_pkg::*; #(
  parameter int Cols = COLS_DEF,
  parameter int Rows = ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       init_done_o,
  tcw_out_if.source  out_o
);

  localparam int Cells  = Rows * Cols;
  localparam int AW     = $clog2(Cells);
  localparam int IW     = $clog2(Cells + 1);
  localparam int CW     = $clog2(Cols);
  localparam int RW     = $clog2(Rows + 1);
  localparam int LinMax = (2**ROW_W - 1) * Cols + 2**COL_W - 1;
  localparam int LW     = $clog2(((LinMax > Cells) ? LinMax : Cells) + 1);

  bk_state_e         state_q, state_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  cmd_t              cmd_q, cmd_d;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [COL_W-1:0]  wc_q, wc_d;
  logic [RW-1:0]     wr_q, wr_d;
  logic [CELL_W-1:0] cell_q, cell_d;
  logic              out_valid_q, out_valid_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;
  logic [CELL_W-1:0] out_cell_q, out_cell_d;

  cmd_t              cmd_cur;
  logic [LW-1:0]     lin;
  logic              pending;
  logic              do_put;
  logic              last_cell;
  logic [31:0]       col_ext;
  logic [31:0]       row_ext;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [CELL_W-1:0] rdata;

  tcw_ram #(
    .Width (CELL_W),
    .Depth (Cells)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Command being worked on: the queue head when idle, else the held copy.
  assign cmd_cur   = (state_q == BK_IDLE) ? head_i : cmd_q;
  assign lin       = LW'(cmd_cur.row) * LW'(Cols) + LW'(cmd_cur.col);
  assign pending   = (row_q == RW'(Rows));
  assign last_cell = (cnt_q == AW'(Cells - 1));
  assign col_ext   = 32'(col_q);
  assign row_ext   = 32'(row_q);

  assign init_done_o = (state_q != BK_INIT);

  // Sequencer next state, store accesses and cursor updates.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    col_d       = col_q;
    row_d       = row_q;
    idx_d       = idx_q;
    wc_d        = wc_q;
    wr_d        = wr_q;
    cell_d      = cell_q;
    out_valid_d = out_valid_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_cell_d  = out_cell_q;
    pop_o       = 1'b0;
    do_put      = 1'b0;
    we          = 1'b0;
    waddr       = cnt_q;
    wdata       = '0;
    raddr       = cnt_q;

    // The result register empties when the receiver takes it.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      BK_INIT: begin
        we = 1'b1;
        if (last_cell) begin
          cnt_d   = '0;
          state_d = BK_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          cmd_d  = head_i;
          cell_d = '0;
          case (head_i.op)
            OP_PUT: begin
              if (pending) begin
                cnt_d   = AW'(Cols);
                state_d = BK_SCR_RD;
              end else begin
                do_put  = 1'b1;
                state_d = BK_DONE;
              end
            end
            OP_NEWLINE: begin
              if (pending) begin
                cnt_d   = AW'(Cols);
                state_d = BK_SCR_RD;
              end else begin
                row_d   = row_q + 1'b1;
                col_d   = '0;
                idx_d   = idx_q + IW'(Cols) - IW'(col_q);
                state_d = BK_DONE;
              end
            end
            OP_CLEAR: begin
              cnt_d   = '0;
              state_d = BK_CLEAR;
            end
            OP_SET: begin
              if (lin > LW'(Cells)) begin
                row_d   = RW'(Rows);
                col_d   = '0;
                idx_d   = IW'(Cells);
                state_d = BK_DONE;
              end else begin
                idx_d   = IW'(lin);
                wc_d    = head_i.col;
                wr_d    = RW'(head_i.row);
                state_d = BK_WRAP;
              end
            end
            OP_READ: begin
              if (head_i.in_range) begin
                raddr   = AW'(lin);
                state_d = BK_READ;
              end else begin
                state_d = BK_DONE;
              end
            end
            default: state_d = BK_DONE;
          endcase
        end
      end
      BK_READ: begin
        cell_d  = rdata;
        state_d = BK_DONE;
      end
      // A column past the row width carries into later rows, one row a cycle.
      BK_WRAP: begin
        if (32'(wc_q) >= Cols) begin
          wc_d = wc_q - COL_W'(Cols);
          wr_d = wr_q + 1'b1;
        end else begin
          col_d   = CW'(wc_q);
          row_d   = wr_q;
          state_d = BK_DONE;
        end
      end
      // Scroll: copy each cell one row up, read then write.
      BK_SCR_RD: begin
        state_d = BK_SCR_WR;
      end
      BK_SCR_WR: begin
        we    = 1'b1;
        waddr = cnt_q - AW'(Cols);
        wdata = rdata;
        if (last_cell) begin
          cnt_d   = AW'(Cells - Cols);
          state_d = BK_ZERO;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = BK_SCR_RD;
        end
      end
      // Scroll: erase the last row, then park the cursor at its start.
      BK_ZERO: begin
        we = 1'b1;
        if (last_cell) begin
          row_d   = RW'(Rows - 1);
          col_d   = '0;
          idx_d   = IW'(Cells - Cols);
          state_d = (cmd_q.op == OP_PUT) ? BK_PUT : BK_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      BK_CLEAR: begin
        we    = 1'b1;
        wdata = {cmd_q.attribute, {CHAR_W{1'b0}}};
        if (last_cell) begin
          row_d   = '0;
          col_d   = '0;
          idx_d   = '0;
          state_d = BK_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      BK_PUT: begin
        do_put  = 1'b1;
        state_d = BK_DONE;
      end
      // Hand the result over once the result register is free.
      BK_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_col_d   = col_ext[COL_W-1:0];
          out_row_d   = row_ext[ROW_W-1:0];
          out_cell_d  = cell_q;
          state_d     = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase

    // Write the character at the cursor and advance by one cell.
    if (do_put) begin
      we    = 1'b1;
      waddr = idx_q[AW-1:0];
      wdata = {cmd_cur.attribute, cmd_cur.char_code};
      idx_d = idx_q + 1'b1;
      if (col_q == CW'(Cols - 1)) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // Control state and cursor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_INIT;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    wc_q       <= wc_d;
    wr_q       <= wr_d;
    cell_q     <= cell_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    out_cell_q <= out_cell_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cursor_col = out_col_q;
  assign out_o.cursor_row = out_row_q;
  assign out_o.cell_char  = out_cell_q[CHAR_W-1:0];
  assign out_o.cell_attr  = out_cell_q[CELL_W-1:CHAR_W];

endmodule

[rtl/text_console_char_writer.sv]
// Top level of the text console character writer.
// Depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_front, tcw_fifo and tcw_back.
//
// Usage: requests arrive on in_i (valid/ready); each accepted transaction
// yields exactly one result transaction on out_o, in order. Functions are
// put character (code 10 is newline), clear screen, set cursor and read cell.
// Every result carries the cursor as column and row; a row equal to Rows
// means a scroll is pending. Reads return the addressed cell, others zero.
// Sequencing: a request enters a two-entry command queue in the cycle it
// is accepted. A put, a newline or a set cursor that saturates past the end
// passes from idle straight to the result; a read first reads the store, and
// any other set cursor first takes a wrap step, repeated once per wrapped row
// when the column exceeds the row width. A clear sweeps every cell, and a put
// or newline that scrolls copies each cell one row up, then erases the last
// row. The slow operations walk the screen store one cell per access.
// Reset: after reset the store is swept to zero, one cell a cycle, and
// in_i.ready stays low until the sweep is done.
// Stall: a result waits in the output register while the receiver is not
// ready; the queue keeps accepting requests until it is full.
module text_console_char_writer import tcw_pkg::*; #(
  parameter int Cols = COLS_DEF,
  parameter int Rows = ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcw_in_if.sink     in_i,
  tcw_out_if.source  out_o
);

  logic init_done;
  logic push;
  logic pop;
  logic fifo_empty;
  logic fifo_full;
  cmd_t cmd_in;
  cmd_t cmd_head;

  // Accept and classify requests.
  tcw_front #(
    .Cols (Cols),
    .Rows (Rows)
  ) u_front (
    .in_i        (in_i),
    .init_done_i (init_done),
    .full_i      (fifo_full),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  // Command queue between front and back.
  tcw_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .data_o  (cmd_head),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  // Carry out commands on the store and the cursor.
  tcw_back #(
    .Cols (Cols),
    .Rows (Rows)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (cmd_head),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .init_done_o (init_done),
    .out_o       (out_o)
  );

  // No request is taken while the reset sweep is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !init_done |-> !in_i.ready)
    else $error("request accepted during reset sweep");

  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !fifo_full)
    else $error("push into full command queue");

  // The back end never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !fifo_empty)
    else $error("pop from empty command queue");

endmodule

[verif/text_console_char_writer_test.sv]
// Testbench for the text console character writer, run at the default screen size.
// It predicts every cursor report and cell read in order. It needs tcw_pkg, tcw_in_if,
// tcw_out_if and the text_console_char_writer RTL.
module text_console_char_writer_test;
  import tcw_pkg::*;

  localparam int CONS_COLS = COLS_DEF;
  localparam int CONS_ROWS = ROWS_DEF;
  localparam int CELLS     = CONS_COLS * CONS_ROWS;

  // Stimulus sizes and budgets for the slow operations.
  localparam int ITEM_TARGET    = 1350;
  localparam int QUIET_FIRST    = 600;
  localparam int QUIET_LAST     = 850;
  localparam int SCROLL_LIMIT   = 70;
  localparam int CLEAR_LIMIT    = 15;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT    = 50000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_TIME  = 20000000;
  localparam int PRINT_LIMIT    = 40;

  // One expected result: cursor position plus the cell read back.
  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
  } console_report_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  text_console_char_writer #(
    .Cols(CONS_COLS),
    .Rows(CONS_ROWS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Predicted screen contents, cursor and the reports still to arrive.
  logic [CELL_W-1:0] screen_cells [CELLS];
  int unsigned       cursor_cell;
  console_report_t   awaited_reports [$];

  // Run statistics.
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned put_count;
  int unsigned newline_count;
  int unsigned clear_count;
  int unsigned set_count;
  int unsigned read_count;
  int unsigned scroll_count;

  // Idling controls shared by the sender and the receiver.
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_request;

  always #1 clk_i = ~clk_i;

  // Screen behavior for one request; updates the predicted state and returns the report.
  function automatic console_report_t apply_console_request(
    input logic [FUNC_W-1:0] func,
    input logic [CHAR_W-1:0] ch,
    input logic [ATTR_W-1:0] attr,
    input logic [COL_W-1:0]  col,
    input logic [ROW_W-1:0]  row
  );
    console_report_t rep;
    int unsigned     pos;
    int unsigned     next_pos;
    int unsigned     idx;
    bit              is_newline;
    rep = '0;
    case (func)
      FUNC_PUT: begin
        pos        = cursor_cell;
        is_newline = (ch == NEWLINE_CODE);
        if (is_newline) begin
          newline_count++;
          next_pos = (pos / CONS_COLS + 1) * CONS_COLS;
        end else begin
          put_count++;
          next_pos = pos + 1;
        end
        // Moving past the end shifts every row up and blanks the last one.
        if (next_pos > CELLS) begin
          scroll_count++;
          for (int i = 0; i + CONS_COLS < CELLS; i++) begin
            screen_cells[i] = screen_cells[i + CONS_COLS];
          end
          for (int i = CELLS - CONS_COLS; i < CELLS; i++) begin
            screen_cells[i] = '0;
          end
          pos         = CELLS - CONS_COLS;
          cursor_cell = pos;
        end else if (is_newline) begin
          cursor_cell = next_pos;
        end
        if (!is_newline && pos < CELLS) begin
          screen_cells[pos] = {attr, ch};
          cursor_cell       = pos + 1;
        end
      end
      FUNC_CLEAR: begin
        clear_count++;
        for (int i = 0; i < CELLS; i++) begin
          screen_cells[i] = {attr, 8'h00};
        end
        cursor_cell = 0;
      end
      FUNC_SET: begin
        set_count++;
        idx         = int'(row) * CONS_COLS + int'(col);
        cursor_cell = (idx > CELLS) ? CELLS : idx;
      end
      default: begin
        read_count++;
        if (int'(col) < CONS_COLS && int'(row) < CONS_ROWS) begin
          idx           = int'(row) * CONS_COLS + int'(col);
          rep.cell_char = screen_cells[idx][CHAR_W-1:0];
          rep.cell_attr = screen_cells[idx][CELL_W-1:CHAR_W];
        end
      end
    endcase
    rep.cursor_col = COL_W'(cursor_cell % CONS_COLS);
    rep.cursor_row = ROW_W'(cursor_cell / CONS_COLS);
    return rep;
  endfunction

  // Prints one mismatch line (up to a limit) and counts it.
  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Offers one request and waits until the transaction is accepted.
  task automatic send_console_request(
    input logic [FUNC_W-1:0] func,
    input logic [CHAR_W-1:0] ch,
    input logic [ATTR_W-1:0] attr,
    input logic [COL_W-1:0]  col,
    input logic [ROW_W-1:0]  row
  );
    logic [FUNC_W-1:0] sent_func;
    logic [COL_W-1:0]  sent_col;
    logic [ROW_W-1:0]  sent_row;
    sent_func = func;
    sent_col  = col;
    sent_row  = row;
    // Every scroll walks the whole store, so once the budget is spent a put
    // with a scroll pending becomes a cursor move back into the screen.
    if (func == FUNC_PUT && cursor_cell == CELLS && scroll_count >= SCROLL_LIMIT) begin
      sent_func = FUNC_SET;
      sent_col  = COL_W'($urandom_range(CONS_COLS - 1));
      sent_row  = ROW_W'($urandom_range(CONS_ROWS - 1));
    end
    while (tx_idle_on && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= sent_func;
    in_ch.char_code <= ch;
    in_ch.attribute <= attr;
    in_ch.col       <= sent_col;
    in_ch.row       <= sent_row;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) begin
      @(posedge clk_i);
    end
    awaited_reports.push_back(apply_console_request(sent_func, ch, attr, sent_col, sent_row));
    requests_sent++;
  endtask

  // Compares one accepted result with the oldest expectation.
  task automatic check_result();
    console_report_t want;
    if (awaited_reports.size() == 0) begin
      report_mismatch($sformatf("result with no request waiting (cursor %0d,%0d)",
                                out_ch.cursor_col, out_ch.cursor_row));
    end else begin
      want = awaited_reports.pop_front();
      if (out_ch.cursor_col !== want.cursor_col) begin
        report_mismatch($sformatf("result %0d cursor_col got %0d expected %0d",
                                  results_checked, out_ch.cursor_col, want.cursor_col));
      end
      if (out_ch.cursor_row !== want.cursor_row) begin
        report_mismatch($sformatf("result %0d cursor_row got %0d expected %0d",
                                  results_checked, out_ch.cursor_row, want.cursor_row));
      end
      if (out_ch.cell_char !== want.cell_char) begin
        report_mismatch($sformatf("result %0d cell_char got %0h expected %0h",
                                  results_checked, out_ch.cell_char, want.cell_char));
      end
      if (out_ch.cell_attr !== want.cell_attr) begin
        report_mismatch($sformatf("result %0d cell_attr got %0h expected %0h",
                                  results_checked, out_ch.cell_attr, want.cell_attr));
      end
    end
    results_checked++;
  endtask

  // Receiver: checks each accepted result, idles at random and holds off on request.
  initial begin : result_receiver
    int unsigned held_cycles;
    held_cycles  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        check_result();
      end
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        held_cycles++;
        if (held_cycles >= RX_HOLD_CYCLES) begin
          hold_request = 1'b0;
          held_cycles  = 0;
        end
      end else begin
        out_ch.ready <= !(rx_idle_on && $urandom_range(99) < 25);
      end
    end
  end

  // Extremes of every field, every function and the corner cases of the cursor.
  task automatic test_directed_cases();
    send_console_request(FUNC_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    send_console_request(FUNC_PUT, 8'h41, 8'h07, 7'd127, 5'd31);
    send_console_request(FUNC_PUT, 8'hFF, 8'hFF, 7'd0, 5'd0);
    send_console_request(FUNC_PUT, 8'h00, 8'h00, 7'd0, 5'd0);
    send_console_request(FUNC_READ, 8'hFF, 8'hFF, 7'd1, 5'd0);
    send_console_request(FUNC_PUT, NEWLINE_CODE, 8'h33, 7'd5, 5'd5);
    // Last cell of the screen, then a put that leaves a scroll pending.
    send_console_request(FUNC_SET, 8'h00, 8'h00, 7'd79, 5'd24);
    send_console_request(FUNC_PUT, 8'h5A, 8'h1E, 7'd0, 5'd0);
    send_console_request(FUNC_READ, 8'h00, 8'h00, 7'd79, 5'd24);
    // A put with a scroll pending scrolls and writes at the start of the last row.
    send_console_request(FUNC_PUT, 8'h42, 8'h70, 7'd0, 5'd0);
    send_console_request(FUNC_READ, 8'h00, 8'h00, 7'd79, 5'd23);
    // Newline on the last row only marks the scroll; a second one performs it.
    send_console_request(FUNC_PUT, NEWLINE_CODE, 8'h00, 7'd0, 5'd0);
    send_console_request(FUNC_PUT, NEWLINE_CODE, 8'hC3, 7'd0, 5'd0);
    send_console_request(FUNC_READ, 8'h00, 8'h00, 7'd0, 5'd23);
    // Cursor moves past the end saturate; a wide column wraps into the next row.
    send_console_request(FUNC_SET, 8'h00, 8'h00, 7'd127, 5'd31);
    send_console_request(FUNC_SET, 8'h00, 8'h00, 7'd100, 5'd3);
    send_console_request(FUNC_SET, 8'h00, 8'h00, 7'd0, 5'd25);
    // Reads outside the screen return zero.
    send_console_request(FUNC_READ, 8'h00, 8'h00, 7'd80, 5'd0);
    send_console_request(FUNC_READ, 8'h00, 8'h00, 7'd0, 5'd25);
    send_console_request(FUNC_READ, 8'hFF, 8'hFF, 7'd127, 5'd31);
    send_console_request(FUNC_CLEAR, 8'hFF, 8'hA5, 7'd0, 5'd0);
    send_console_request(FUNC_READ, 8'h00, 8'h00, 7'd40, 5'd12);
    send_console_request(FUNC_CLEAR, 8'h00, 8'h00, 7'd127, 5'd31);
    send_console_request(FUNC_READ, 8'h00, 8'h00, 7'd79, 5'd24);
  endtask

  // The receiver holds off while the sender keeps offering, so the queue fills.
  task automatic test_output_backpressure();
    send_console_request(FUNC_SET, 8'h00, 8'h00, 7'd0, 5'd5);
    hold_request = 1'b1;
    for (int k = 0; k < 40; k++) begin
      if (k % 4 == 3) begin
        send_console_request(FUNC_READ, CHAR_W'($urandom_range(255)),
                             ATTR_W'($urandom_range(255)),
                             COL_W'($urandom_range(CONS_COLS - 1)), 5'd5);
      end else begin
        send_console_request(FUNC_PUT, CHAR_W'($urandom_range(255)),
                             ATTR_W'($urandom_range(255)),
                             COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)));
      end
    end
  endtask

  // One request with random content of any function.
  task automatic send_random_single();
    int unsigned       pick;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    pick = $urandom_range(99);
    ch   = CHAR_W'($urandom_range(255));
    attr = ATTR_W'($urandom_range(255));
    col  = COL_W'($urandom_range(127));
    row  = ROW_W'($urandom_range(31));
    if (pick < 50) begin
      func = FUNC_PUT;
    end else if (pick < 60) begin
      func = FUNC_PUT;
      ch   = NEWLINE_CODE;
    end else if (pick < 80) begin
      func = FUNC_READ;
      if ($urandom_range(9) != 0) begin
        col = COL_W'($urandom_range(CONS_COLS - 1));
        row = ROW_W'($urandom_range(CONS_ROWS - 1));
      end
    end else if (pick < 97) begin
      func = FUNC_SET;
      if ($urandom_range(3) != 0) begin
        col = COL_W'($urandom_range(CONS_COLS - 1));
        row = ROW_W'($urandom_range(CONS_ROWS - 1));
      end
    end else if (clear_count < CLEAR_LIMIT) begin
      func = FUNC_CLEAR;
    end else begin
      func = FUNC_READ;
    end
    send_console_request(func, ch, attr, col, row);
  endtask

  // A line of text from a chosen row, often near the bottom so that it scrolls,
  // followed by reads of the rows it touched.
  task automatic send_line_burst();
    int unsigned       start_row;
    int unsigned       length;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  start_col;
    logic [ROW_W-1:0]  read_row;
    if ($urandom_range(1) == 0) begin
      start_row = $urandom_range(CONS_ROWS - 1);
    end else begin
      start_row = $urandom_range(CONS_ROWS - 1, CONS_ROWS - 3);
    end
    start_col = ($urandom_range(1) == 0) ? 7'd0 : COL_W'($urandom_range(CONS_COLS - 1));
    send_console_request(FUNC_SET, CHAR_W'($urandom_range(255)),
                         ATTR_W'($urandom_range(255)), start_col, ROW_W'(start_row));
    length = $urandom_range(100, 1);
    for (int k = 0; k < length; k++) begin
      ch = CHAR_W'($urandom_range(255));
      if ($urandom_range(19) == 0) begin
        ch = NEWLINE_CODE;
      end
      send_console_request(FUNC_PUT, ch, ATTR_W'($urandom_range(255)),
                           COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)));
    end
    for (int k = 0; k < 4; k++) begin
      read_row = (k < 2) ? ROW_W'(start_row) : ROW_W'(CONS_ROWS - 1 - (k % 2));
      send_console_request(FUNC_READ, CHAR_W'($urandom_range(255)),
                           ATTR_W'($urandom_range(255)),
                           COL_W'($urandom_range(CONS_COLS - 1)), read_row);
    end
  endtask

  // Random single requests of any function, mixed with line bursts.
  task automatic test_random_traffic();
    while (requests_sent < ITEM_TARGET) begin
      tx_idle_on = !(requests_sent >= QUIET_FIRST && requests_sent < QUIET_LAST);
      rx_idle_on = tx_idle_on;
      if ($urandom_range(99) < 15) begin
        send_line_burst();
      end else begin
        send_random_single();
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Watchdog for a hung run.
  initial begin : run_watchdog
    #(WATCHDOG_TIME);
    $display("Timeout: the run did not finish in time.");
    $display("CHECKS FAILED");
    $finish;
  end

  // Reset, the tests in turn, then the drain and the verdict.
  initial begin : test_sequence
    int unsigned drain_cycles;
    foreach (screen_cells[i]) begin
      screen_cells[i] = '0;
    end
    cursor_cell     = 0;
    requests_sent   = 0;
    results_checked = 0;
    mismatch_count  = 0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    hold_request    = 1'b0;
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_PUT;
    in_ch.char_code <= '0;
    in_ch.attribute <= '0;
    in_ch.col       <= '0;
    in_ch.row       <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_output_backpressure();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    drain_cycles = 0;
    while (awaited_reports.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (awaited_reports.size() != 0) begin
      $display("Timeout: %0d results never arrived.", awaited_reports.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      $display("Covered %0d requests: %0d puts, %0d newlines, %0d clears,",
               requests_sent, put_count, newline_count, clear_count);
      $display("%0d cursor sets, %0d reads, %0d scrolls, %0d results, %0d mismatches.",
               set_count, read_count, scroll_count, results_checked, mismatch_count);
      if (mismatch_count == 0) begin
        $display("ALL CHECKS PASSED");
      end else begin
        $display("CHECKS FAILED");
      end
      $finish;
    end
  end

endmodule
